// ===== rtl/assert_macros.svh =====
// Assertion helpers for the bound checker ksbd_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, masked during reset.
`define KS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define KS_ASSERT_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error("assertion failed");

`endif

// ===== rtl/ksbd_pkg.sv =====
package ksbd_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int SIDX_W = $clog2(MAX_SAMPLES + 1);
  localparam int BP_W = 12;
  localparam int CFG_W = 24;

  localparam logic [2:0] REG_ANGLE = 3'd0;
  localparam logic [2:0] REG_PNOISE = 3'd1;
  localparam logic [2:0] REG_MNOISE = 3'd2;
  localparam logic [2:0] REG_GATE = 3'd3;
  localparam logic [2:0] REG_SEED = 3'd4;

  localparam logic [CFG_W-1:0] RST_ANGLE = 24'd73204;
  localparam logic [CFG_W-1:0] RST_PNOISE = 24'd167772;
  localparam logic [CFG_W-1:0] RST_MNOISE = 24'd15099;
  localparam logic [CFG_W-1:0] RST_GATE = 24'd251658;
  localparam logic [CFG_W-1:0] RST_SEED = 24'd371669;

  // ALU operations
  localparam logic [1:0] OP_RAW = 2'd0;  // full 128-bit product
  localparam logic [1:0] OP_MS24 = 2'd1; // (x*y) >> 24, saturated
  localparam logic [1:0] OP_MS32 = 2'd2; // (x*y) >> 32, saturated
  localparam logic [1:0] OP_DIV = 2'd3;  // x*y/d, saturated

  typedef struct packed {
    logic              start;
    logic [1:0]        op;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic [63:0]       d;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic signed [63:0] res;
    logic [127:0]      prod;
  } alu_rsp_t;

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return {1'b0, {63{1'b1}}};
    if (a[63] && b[63] && !s[63]) return {1'b1, 63'b0};
    return s;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
    if (x[63:47] != {17{x[63]}}) return x[63] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    return x[47:0];
  endfunction

  function automatic logic signed [63:0] ext48(input logic signed [47:0] x);
    return {{16{x[47]}}, x};
  endfunction

endpackage

// ===== rtl/ksbd_alu.sv =====
module ksbd_alu import ksbd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_MUL = 2'd1;
  localparam logic [1:0] A_DIV = 2'd2;
  localparam logic [1:0] A_FIN = 2'd3;

  logic [1:0]   aphase;
  logic [1:0]   k;
  logic [6:0]   cnt;
  logic [1:0]   op;
  logic         neg;
  logic [63:0]  mx, my, dv, rem;
  logic [127:0] acc;

  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_sh, acc_sum;
  logic [63:0]  r1, diff;
  logic         ge;
  logic         sat;
  logic [62:0]  mag;
  logic [63:0]  mag_s;

  // one 32x32 partial product per cycle
  always_comb begin
    ah = k[1] ? mx[63:32] : mx[31:0];
    bh = k[0] ? my[63:32] : my[31:0];
    pp = ah * bh;
    case (k)
      2'd0: pp_sh = {64'b0, pp};
      2'd3: pp_sh = {pp, 64'b0};
      default: pp_sh = {32'b0, pp, 32'b0};
    endcase
    acc_sum = acc + pp_sh;
  end

  // restoring division, one quotient bit per cycle
  always_comb begin
    r1 = {rem[62:0], acc[127]};
    diff = r1 - dv;
    ge = rem[63] || (r1 >= dv);
  end

  always_comb begin
    case (op)
      OP_MS24: begin
        sat = |acc[127:87];
        mag = acc[86:24];
      end
      OP_MS32: begin
        sat = |acc[127:95];
        mag = acc[94:32];
      end
      default: begin
        sat = |acc[127:63];
        mag = acc[62:0];
      end
    endcase
    mag_s = {1'b0, sat ? {63{1'b1}} : mag};
    rsp.done = (aphase == A_FIN);
    rsp.res = neg ? -$signed(mag_s) : $signed(mag_s);
    rsp.prod = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      aphase <= A_IDLE;
    end else begin
      unique case (aphase)
        A_IDLE: begin
          if (req.start) begin
            mx <= req.x[63] ? 64'(-req.x) : req.x;
            my <= req.y[63] ? 64'(-req.y) : req.y;
            neg <= req.x[63] ^ req.y[63];
            op <= req.op;
            dv <= req.d;
            acc <= '0;
            rem <= '0;
            k <= 2'd0;
            cnt <= '0;
            aphase <= A_MUL;
          end
        end
        A_MUL: begin
          acc <= acc_sum;
          k <= k + 2'd1;
          if (k == 2'd3) aphase <= (op == OP_DIV) ? A_DIV : A_FIN;
        end
        A_DIV: begin
          rem <= ge ? diff : r1;
          acc <= {acc[126:0], ge};
          cnt <= cnt + 7'd1;
          if (cnt == 7'd127) aphase <= A_FIN;
        end
        A_FIN: aphase <= A_IDLE;
        default: aphase <= A_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/kalman_scan_breakpoint_detector_core.sv =====
// Output: a seeding start, a gate failure's end/start pair or a lost sample's end is
//   loaded into the output buffer from the hold state once that buffer is empty.
// Flow: one request at a time; in_ready is low from acceptance until its
//   breakpoints are in the output buffer; a tracked request that passes the gate
//   runs six multiplies and five divisions on the ALU.
// Reset: synchronous, clears control, filter state and restores register defaults.
module kalman_scan_breakpoint_detector_core import ksbd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [23:0]      range_value,
  input  logic             range_invalid,
  input  logic             first_of_scan,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [BP_W-1:0]  bp_index,
  output logic             bp_kind,
  output logic             bp_last,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_CALC = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  // micro-steps, one ALU operation each
  localparam logic [3:0] SP_SR = 4'd0;   // spread * range
  localparam logic [3:0] SP_SRA = 4'd1;  // sr * angle
  localparam logic [3:0] SP_SVV = 4'd2;  // seed cov_vv
  localparam logic [3:0] SP_SRR = 4'd3;  // seed cov_rr
  localparam logic [3:0] SP_T1 = 4'd4;   // a * rate
  localparam logic [3:0] SP_T2 = 4'd5;   // a * vv
  localparam logic [3:0] SP_T3 = 4'd6;   // a * rv
  localparam logic [3:0] SP_T4 = 4'd7;   // a * rv'
  localparam logic [3:0] SP_VV = 4'd8;   // innovation squared
  localparam logic [3:0] SP_GS = 4'd9;   // gate * s
  localparam logic [3:0] SP_D1 = 4'd10;
  localparam logic [3:0] SP_D2 = 4'd11;
  localparam logic [3:0] SP_D3 = 4'd12;
  localparam logic [3:0] SP_D4 = 4'd13;
  localparam logic [3:0] SP_D5 = 4'd14;

  // breakpoints produced by one request
  localparam logic [1:0] RES_NONE = 2'd0;
  localparam logic [1:0] RES_START = 2'd1;
  localparam logic [1:0] RES_END = 2'd2;
  localparam logic [1:0] RES_BOTH = 2'd3;

  logic [2:0] state;
  logic [3:0] step;
  logic [1:0] res_mode;

  // configuration
  logic [CFG_W-1:0] angle_step, process_noise, measure_noise, gate_level, seed_spread;

  // filter state
  logic signed [47:0] est_range, est_rate;
  logic signed [63:0] cov_rr, cov_rv, cov_vv;
  logic               tracking;
  logic [SIDX_W-1:0]  sample_index;

  // per-request working registers
  logic [23:0]        range_r;
  logic [BP_W-1:0]    cur_idx;
  logic signed [63:0] sr, tmp, prv, prr, pvv, v, s;
  logic signed [47:0] xr;
  logic [127:0]       vvp;

  // output buffer: head plus one pending entry
  logic            pend_valid;
  logic [BP_W-1:0] pend_index;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic signed [63:0] a_s, q_s, r_s, s_raw;
  logic [SIDX_W-1:0]  idx_eff;
  logic               trk_eff;
  logic               in_fire, out_fire;

  assign a_s = {40'b0, angle_step};
  assign q_s = {32'b0, process_noise, 8'b0};
  assign r_s = {32'b0, measure_noise, 8'b0};
  assign s_raw = add_sat(prr, r_s);

  assign in_ready = (state == ST_IDLE);
  assign in_fire = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign idx_eff = first_of_scan ? '0 : sample_index;
  assign trk_eff = first_of_scan ? 1'b0 : tracking;

  ksbd_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // operand selection for the current step
  always_comb begin
    alu_req.start = (state == ST_ISSUE);
    alu_req.d = s;
    alu_req.op = OP_MS24;
    alu_req.x = a_s;
    alu_req.y = '0;
    case (step)
      SP_SR: begin
        alu_req.op = OP_RAW;
        alu_req.x = {40'b0, seed_spread};
        alu_req.y = {40'b0, range_r};
      end
      SP_SRA: begin
        alu_req.x = sr;
        alu_req.y = a_s;
      end
      SP_SVV: begin
        alu_req.op = OP_MS32;
        alu_req.x = sr;
        alu_req.y = sr;
      end
      SP_SRR: begin
        alu_req.op = OP_MS32;
        alu_req.x = tmp;
        alu_req.y = tmp;
      end
      SP_T1: alu_req.y = ext48(est_rate);
      SP_T2: alu_req.y = cov_vv;
      SP_T3: alu_req.y = cov_rv;
      SP_T4: alu_req.y = prv;
      SP_VV: begin
        alu_req.op = OP_RAW;
        alu_req.x = v;
        alu_req.y = v;
      end
      SP_GS: begin
        alu_req.op = OP_RAW;
        alu_req.x = {40'b0, gate_level};
        alu_req.y = s;
      end
      SP_D1: begin
        alu_req.op = OP_DIV;
        alu_req.x = prr;
        alu_req.y = v;
      end
      SP_D2: begin
        alu_req.op = OP_DIV;
        alu_req.x = prv;
        alu_req.y = v;
      end
      SP_D3: begin
        alu_req.op = OP_DIV;
        alu_req.x = prr;
        alu_req.y = prr;
      end
      SP_D4: begin
        alu_req.op = OP_DIV;
        alu_req.x = prr;
        alu_req.y = prv;
      end
      SP_D5: begin
        alu_req.op = OP_DIV;
        alu_req.x = prv;
        alu_req.y = prv;
      end
      default: alu_req.op = OP_MS24;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_step <= RST_ANGLE;
      process_noise <= RST_PNOISE;
      measure_noise <= RST_MNOISE;
      gate_level <= RST_GATE;
      seed_spread <= RST_SEED;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ANGLE: angle_step <= cfg_data;
        REG_PNOISE: process_noise <= cfg_data;
        REG_MNOISE: measure_noise <= cfg_data;
        REG_GATE: gate_level <= cfg_data;
        REG_SEED: seed_spread <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= SP_SR;
      res_mode <= RES_NONE;
      tracking <= 1'b0;
      sample_index <= '0;
      est_range <= '0;
      est_rate <= '0;
      cov_rr <= '0;
      cov_rv <= '0;
      cov_vv <= '0;
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (out_fire) begin
        out_valid <= pend_valid;
        bp_index <= pend_index;
        bp_kind <= 1'b1;
        bp_last <= 1'b1;
        pend_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            range_r <= range_value;
            res_mode <= RES_NONE;
            state <= ST_HOLD;
            tracking <= trk_eff;
            sample_index <= idx_eff;
            if (idx_eff < SIDX_W'(MAX_SAMPLES)) begin
              cur_idx <= idx_eff[BP_W-1:0];
              sample_index <= idx_eff + SIDX_W'(1);
              if (!trk_eff) begin
                if (!range_invalid) begin
                  res_mode <= RES_START;
                  step <= SP_SR;
                  state <= ST_ISSUE;
                end
              end else if (range_invalid) begin
                // sample lost: close the segment and wait in the gap
                tracking <= 1'b0;
                res_mode <= RES_END;
              end else begin
                step <= SP_T1;
                state <= ST_ISSUE;
              end
            end
          end
        end
        ST_ISSUE: state <= ST_WAIT;
        ST_WAIT: begin
          if (alu_rsp.done) begin
            state <= ST_ISSUE;
            step <= step + 4'd1;
            case (step)
              SP_SR: sr <= alu_rsp.prod[63:0];
              SP_SRA: tmp <= alu_rsp.res;
              SP_SVV: cov_vv <= alu_rsp.res;
              SP_SRR: begin
                cov_rr <= alu_rsp.res;
                cov_rv <= '0;
                est_range <= {8'b0, range_r, 16'b0};
                est_rate <= '0;
                tracking <= 1'b1;
                state <= ST_HOLD;
              end
              SP_T1: xr <= sat48(add_sat(ext48(est_range), alu_rsp.res));
              SP_T2: prv <= add_sat(cov_rv, alu_rsp.res);
              SP_T3: tmp <= add_sat(cov_rr, alu_rsp.res);
              SP_T4: begin
                prr <= add_sat(tmp, add_sat(alu_rsp.res, q_s));
                state <= ST_CALC;
              end
              SP_VV: vvp <= alu_rsp.prod;
              SP_GS: begin
                // chi-square gate: v^2 >= gate * s (gate in Q8.16)
                if (vvp >= {alu_rsp.prod[111:0], 16'b0}) begin
                  res_mode <= RES_BOTH;
                  step <= SP_SR;
                end
              end
              SP_D1: est_range <= sat48(add_sat(ext48(xr), alu_rsp.res));
              SP_D2: est_rate <= sat48(add_sat(ext48(est_rate), alu_rsp.res));
              SP_D3: cov_rr <= add_sat(prr, -alu_rsp.res);
              SP_D4: cov_rv <= add_sat(prv, -alu_rsp.res);
              SP_D5: begin
                cov_vv <= add_sat(pvv, -alu_rsp.res);
                state <= ST_HOLD;
              end
              default: state <= ST_HOLD;
            endcase
          end
        end
        ST_CALC: begin
          pvv <= add_sat(cov_vv, q_s);
          v <= $signed({24'b0, range_r, 16'b0}) - ext48(xr);
          s <= (s_raw < 64'sd1) ? 64'sd1 : s_raw;
          step <= SP_VV;
          state <= ST_ISSUE;
        end
        ST_HOLD: begin
          // hand the breakpoints over once the buffer is empty
          if (!out_valid && !pend_valid) begin
            state <= ST_IDLE;
            case (res_mode)
              RES_START: begin
                out_valid <= 1'b1;
                bp_index <= cur_idx;
                bp_kind <= 1'b1;
                bp_last <= 1'b1;
              end
              RES_END: begin
                out_valid <= 1'b1;
                bp_index <= cur_idx - BP_W'(1);
                bp_kind <= 1'b0;
                bp_last <= 1'b1;
              end
              RES_BOTH: begin
                out_valid <= 1'b1;
                bp_index <= cur_idx - BP_W'(1);
                bp_kind <= 1'b0;
                bp_last <= 1'b0;
                pend_valid <= 1'b1;
                pend_index <= cur_idx;
              end
              default: ;
            endcase
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/ksbd_chk.sv =====
`include "assert_macros.svh"
module ksbd_chk import ksbd_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [BP_W-1:0] bp_index,
  input logic            bp_kind,
  input logic            bp_last
);

  // a stalled breakpoint stays offered
  `KS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // busy straight after taking a request
  `KS_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)
  // an end that is not last is followed at once by the matching start
  `KS_ASSERT_NEXT(a_pair, out_valid && out_ready && !bp_last,
    out_valid && bp_kind && bp_last && (bp_index == $past(bp_index) + BP_W'(1)))
  // reset leaves the block empty and ready
  `KS_ASSERT_RST(a_reset, rst, !out_valid && in_ready)

endmodule

bind kalman_scan_breakpoint_detector_core ksbd_chk u_chk (.*);

// ===== tb/sv/kalman_scan_breakpoint_detector_core_checker.sv =====
`timescale 1ns / 100ps

module kalman_scan_breakpoint_detector_core_checker import ksbd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [23:0]      range_value,
  input  logic             range_invalid,
  input  logic             first_of_scan,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [BP_W-1:0]  bp_index,
  input  logic             bp_kind,
  input  logic             bp_last,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               fail_count,
  output int               awaited,
  output int               requests_seen,
  output int               breakpoints_seen
);

  typedef struct packed {
    logic [BP_W-1:0] idx;
    logic            kind;
    logic            last;
  } breakpoint_t;

  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  breakpoint_t due_bps[$];

  logic [CFG_W-1:0] angle, pnoise, mnoise, gate, spread;
  logic signed [63:0] est_range, est_rate, cov_rr, cov_rv, cov_vv;
  logic tracking;
  int next_idx;

  function automatic void queue_bp(input logic [BP_W-1:0] idx_v, input logic kind_v,
                                   input logic last_v);
    breakpoint_t bp;
    bp.idx = idx_v;
    bp.kind = kind_v;
    bp.last = last_v;
    due_bps.insert(due_bps.size(), bp);
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function automatic logic signed [63:0] clamp_mag(input logic [127:0] m, input bit neg);
    logic [63:0] r;
    r = (m[127:63] != 0) ? POS_MAX : m[63:0];
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [63:0] scaled_mul(input logic signed [63:0] x,
                                                    input logic signed [63:0] y,
                                                    input int sh);
    logic [127:0] p;
    p = {64'b0, mag(x)} * {64'b0, mag(y)};
    return clamp_mag(p >> sh, x[63] != y[63]);
  endfunction

  function automatic logic signed [63:0] ratio_mul(input logic signed [63:0] x,
                                                   input logic signed [63:0] y,
                                                   input logic signed [63:0] d);
    logic [127:0] p;
    p = {64'b0, mag(x)} * {64'b0, mag(y)};
    return clamp_mag(p / {64'b0, d}, x[63] != y[63]);
  endfunction

  function automatic logic signed [63:0] sum_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'b0} : POS_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] clip48(input logic signed [63:0] x);
    if (x > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (x < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return x;
  endfunction

  task automatic seed_filter(input logic [23:0] rng);
    logic signed [63:0] sr, sra;
    sr = {16'b0, spread * {24'b0, rng}};
    sra = scaled_mul(sr, {40'b0, angle}, 24);
    est_range = {24'b0, rng, 16'b0};
    est_rate = 0;
    cov_vv = scaled_mul(sr, sr, 32);
    cov_rr = scaled_mul(sra, sra, 32);
    cov_rv = 0;
    tracking = 1'b1;
  endtask

  task automatic track_sample(input logic [23:0] rng, input logic inv, input logic fos);
    int cur;
    logic signed [63:0] a, q, xr, prv, prr, pvv, v, s;
    logic [127:0] v2, gs;
    if (fos) begin
      next_idx = 0;
      tracking = 1'b0;
    end
    if (next_idx >= MAX_SAMPLES) return;
    cur = next_idx;
    next_idx++;
    if (!tracking) begin
      if (inv) return;
      seed_filter(rng);
      queue_bp(cur[BP_W-1:0], 1'b1, 1'b1);
      return;
    end
    if (inv) begin
      tracking = 1'b0;
      queue_bp(BP_W'(cur - 1), 1'b0, 1'b1);
      return;
    end
    a = {40'b0, angle};
    q = {32'b0, pnoise, 8'b0};
    xr = clip48(sum_sat(est_range, scaled_mul(a, est_rate, 24)));
    prv = sum_sat(cov_rv, scaled_mul(a, cov_vv, 24));
    prr = sum_sat(sum_sat(cov_rr, scaled_mul(a, cov_rv, 24)),
                  sum_sat(scaled_mul(a, prv, 24), q));
    pvv = sum_sat(cov_vv, q);
    v = $signed({24'b0, rng, 16'b0}) - xr;
    s = sum_sat(prr, {32'b0, mnoise, 8'b0});
    if (s < 1) s = 1;
    v2 = {64'b0, mag(v)} * {64'b0, mag(v)};
    gs = ({104'b0, gate} * {64'b0, s}) << 16;
    if (v2 >= gs) begin
      // gate failure: close the old segment and open a new one here
      seed_filter(rng);
      queue_bp(BP_W'(cur - 1), 1'b0, 1'b0);
      queue_bp(cur[BP_W-1:0], 1'b1, 1'b1);
      return;
    end
    est_range = clip48(sum_sat(xr, ratio_mul(prr, v, s)));
    est_rate = clip48(sum_sat(est_rate, ratio_mul(prv, v, s)));
    cov_rr = sum_sat(prr, -ratio_mul(prr, prr, s));
    cov_rv = sum_sat(prv, -ratio_mul(prr, prv, s));
    cov_vv = sum_sat(pvv, -ratio_mul(prv, prv, s));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      angle = RST_ANGLE; pnoise = RST_PNOISE; mnoise = RST_MNOISE;
      gate = RST_GATE; spread = RST_SEED;
      est_range = 0; est_rate = 0; cov_rr = 0; cov_rv = 0; cov_vv = 0;
      tracking = 1'b0;
      next_idx = 0;
      due_bps.delete();
      fail_count = 0; requests_seen = 0; breakpoints_seen = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ANGLE:  angle = cfg_data;
          REG_PNOISE: pnoise = cfg_data;
          REG_MNOISE: mnoise = cfg_data;
          REG_GATE:   gate = cfg_data;
          REG_SEED:   spread = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        breakpoints_seen++;
        if (due_bps.size() == 0) begin
          $error("unexpected breakpoint idx %0d kind %0d last %0d", bp_index, bp_kind, bp_last);
          fail_count++;
        end else begin
          breakpoint_t e;
          e = due_bps.pop_front();
          if (bp_index !== e.idx) begin
            $error("bp_index: expected %0d, got %0d", e.idx, bp_index);
            fail_count++;
          end
          if (bp_kind !== e.kind) begin
            $error("bp_kind: expected %0d, got %0d", e.kind, bp_kind);
            fail_count++;
          end
          if (bp_last !== e.last) begin
            $error("bp_last: expected %0d, got %0d", e.last, bp_last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        requests_seen++;
        track_sample(range_value, range_invalid, first_of_scan);
      end
    end
    awaited = due_bps.size();
  end

endmodule

// ===== tb/sv/kalman_scan_breakpoint_detector_core_tb.sv =====
`timescale 1ns / 100ps

module kalman_scan_breakpoint_detector_core_tb;
  import ksbd_pkg::*;

  // settle time for a tracked request still in flight after the last breakpoint
  localparam int SETTLE_CYCLES = 1000;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [23:0]      range_value;
  logic             range_invalid;
  logic             first_of_scan;
  logic             out_valid;
  logic             out_ready;
  logic [BP_W-1:0]  bp_index;
  logic             bp_kind;
  logic             bp_last;
  logic             cfg_write;
  logic [2:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  int  fail_count, awaited, requests_seen, breakpoints_seen;
  bit  steady;   // when set, neither side idles

  kalman_scan_breakpoint_detector_core i_dut (
    .clk, .rst, .in_valid, .in_ready, .range_value, .range_invalid, .first_of_scan,
    .out_valid, .out_ready, .bp_index, .bp_kind, .bp_last,
    .cfg_write, .cfg_index, .cfg_data
  );

  kalman_scan_breakpoint_detector_core_checker i_checker (
    .clk, .rst, .in_valid, .in_ready, .range_value, .range_invalid, .first_of_scan,
    .out_valid, .out_ready, .bp_index, .bp_kind, .bp_last,
    .cfg_write, .cfg_index, .cfg_data,
    .fail_count, .awaited, .requests_seen, .breakpoints_seen
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #100_000_000;
    $display("kalman_scan_breakpoint_detector_core: mismatch");
    $finish;
  end

  function automatic int idle_draw();
    return steady ? 0 : $urandom_range(0, 17);
  endfunction

  // one request; valid stays high across back-to-back requests
  task automatic send_sample(input logic [23:0] rng, input logic inv, input logic fos);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    range_value <= rng;
    range_invalid <= inv;
    first_of_scan <= fos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // sender holds off until every breakpoint is out and the core has gone quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] ang, input logic [CFG_W-1:0] pn,
                            input logic [CFG_W-1:0] mn, input logic [CFG_W-1:0] gt,
                            input logic [CFG_W-1:0] sp);
    logic [CFG_W-1:0] vals [5];
    vals = '{ang, pn, mn, gt, sp};
    drain();
    for (int k = REG_ANGLE; k <= REG_SEED; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= k[2:0];
      cfg_data <= vals[k];
      @(posedge clk);
    end
    // unused indexes must leave the register set alone
    for (int k = REG_SEED + 1; k < 8; k++) begin
      cfg_index <= k[2:0];
      cfg_data <= CFG_W'($urandom());
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // random scans: mostly smooth segments, with jumps, drop-outs and noise
  task automatic random_scans(input int n_items);
    int sent, seg_len;
    int base, slope;
    logic [23:0] rng;
    sent = 0;
    while (sent < n_items) begin
      seg_len = $urandom_range(10, 70);
      base = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                         : $urandom_range(6554, 30 * 65536);
      slope = $signed($urandom_range(0, 4000)) - 2000;
      for (int k = 0; k < seg_len && sent < n_items; k++) begin
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) base = $urandom_range(0, 24'hFFFFFF);
        rng = 24'(base + slope * k + $signed($urandom_range(0, 64)) - 32);
        if (pick >= 96) rng = 24'($urandom());
        send_sample(rng, (pick >= 4 && pick < 9), k == 0);
        sent++;
      end
    end
  endtask

  // receiver stalls at random
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    range_value <= '0;
    range_invalid <= 1'b0;
    first_of_scan <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= REG_ANGLE;
    cfg_data <= '0;
    steady = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: leading invalid, range extremes, drop-out, gate failures,
    // mid-scan restart
    send_sample(24'd0, 1'b1, 1'b1);
    send_sample(24'hFFFFFF, 1'b1, 1'b0);
    send_sample(24'd0, 1'b0, 1'b0);
    send_sample(24'd0, 1'b0, 1'b0);
    send_sample(24'hFFFFFF, 1'b0, 1'b0);
    send_sample(24'hFFFFFF, 1'b0, 1'b0);
    send_sample(24'd0, 1'b0, 1'b0);
    send_sample(24'd0, 1'b1, 1'b0);
    send_sample(24'd0, 1'b1, 1'b0);
    for (int k = 0; k < 6; k++) send_sample(24'd327680 + 24'(k * 900), 1'b0, 1'b0);
    send_sample(24'd327680, 1'b0, 1'b1);
    send_sample(24'd330000, 1'b0, 1'b0);
    send_sample(24'd332000, 1'b1, 1'b0);
    send_sample(24'd332000, 1'b0, 1'b0);

    // zero noise and zero angle: the innovation variance collapses to one LSB
    write_regs('0, '0, '0, 24'd251658, '0);
    send_sample(24'd1000, 1'b0, 1'b1);
    send_sample(24'd1000, 1'b0, 1'b0);
    send_sample(24'd1001, 1'b0, 1'b0);
    random_scans(40);

    write_regs(RST_ANGLE, RST_PNOISE, RST_MNOISE, RST_GATE, RST_SEED);
    random_scans(260);
    steady = 1'b1;
    random_scans(100);
    steady = 1'b0;

    write_regs('1, '1, '1, '1, '1);
    random_scans(200);

    write_regs('0, '0, '0, '0, '0);   // gate of zero fails every tracked sample
    random_scans(150);

    write_regs(CFG_W'($urandom()), CFG_W'($urandom()), CFG_W'($urandom()),
               CFG_W'($urandom()), CFG_W'($urandom()));
    random_scans(200);

    write_regs(CFG_W'($urandom_range(0, 200000)), CFG_W'($urandom_range(0, 400000)),
               CFG_W'($urandom_range(0, 40000)), CFG_W'($urandom_range(0, 1000000)),
               CFG_W'($urandom_range(0, 800000)));
    random_scans(250);

    write_regs(RST_ANGLE, RST_PNOISE, RST_MNOISE, RST_GATE, RST_SEED);
    random_scans(200);

    drain();
    $display("Requests accepted: %0d, breakpoints checked: %0d over seven register settings",
             requests_seen, breakpoints_seen);
    $display("Covered seeding, drop-outs, gate failures, zero variance and output stalls");
    if (fail_count == 0 && awaited == 0) begin
      $display("kalman_scan_breakpoint_detector_core: match");
    end else begin
      $display("kalman_scan_breakpoint_detector_core: mismatch");
    end
    $finish;
  end

endmodule
